// ===== rtl/sled_pkg.sv =====
// Shared types and constants of the string literal escape decoder.
`timescale 1ns / 1ps

package sled_pkg;

  // result kinds carried on out_tuser
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // register index of append_nul (paddr[2])
  localparam logic REG_IDX_APPEND_NUL = 1'b0;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } res_t;

  // one queue entry: the results caused by one character
  typedef struct packed {
    logic two;   // r1 follows r0
    res_t r0;
    res_t r1;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/sled_front.sv =====
// Front end: accepts characters and runs the literal/escape parser.
`timescale 1ns / 1ps

module sled_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 append_nul,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] text_char
  input  sled_pkg::q_status_t  q_st,
  output logic                 q_push,
  output sled_pkg::q_entry_t   q_wdata
);

  typedef enum logic [6:0] {
    PH_OPEN  = 7'b0000001,
    PH_STR   = 7'b0000010,
    PH_ESC   = 7'b0000100,
    PH_HEX   = 7'b0001000,
    PH_OCT   = 7'b0010000,
    PH_CLOSE = 7'b0100000,
    PH_DRAIN = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic           emit;
    sled_pkg::res_t r;
    phase_t         ph;
  } lit_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_X     = 8'h78;

  phase_t     phase_r, phase_nxt;
  logic [7:0] accum_r, accum_nxt;
  logic [1:0] oct_r, oct_nxt;
  logic       hex_seen_r, hex_seen_nxt;

  logic           fire;
  lit_t           lit;
  logic [4:0]     hx;       // {valid, value}
  logic           is_oct;
  phase_t         err_ph;
  logic           em_a, em_b;
  sled_pkg::res_t res_a, res_b;
  logic           esc_hit;
  logic [7:0]     esc_val;

  // ordinary character inside a literal
  function automatic lit_t literal_step(input logic [7:0] c);
    lit_t l;
    l.emit   = 1'b0;
    l.r.data = c;
    l.r.kind = sled_pkg::KIND_DATA;
    l.ph     = PH_STR;
    if (c == CH_NUL) begin
      l.emit   = 1'b1;
      l.r.data = 8'h00;
      l.r.kind = sled_pkg::KIND_ERROR;
      l.ph     = PH_OPEN;
    end else if (c == CH_QUOTE) begin
      l.ph = PH_CLOSE;
    end else if (c == CH_BSL) begin
      l.ph = PH_ESC;
    end else begin
      l.emit = 1'b1;
    end
    return l;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  assign in_tready = !q_st.full;
  assign fire      = in_tvalid && in_tready;

  always_comb begin
    lit     = literal_step(in_tdata);
    hx      = hex_val(in_tdata);
    is_oct  = in_tdata inside {[8'h30:8'h37]};
    err_ph  = (in_tdata == CH_NUL) ? PH_OPEN : PH_DRAIN;

    phase_nxt    = phase_r;
    accum_nxt    = accum_r;
    oct_nxt      = oct_r;
    hex_seen_nxt = hex_seen_r;
    em_a         = 1'b0;
    em_b         = 1'b0;
    res_a        = '{data: 8'h00, kind: sled_pkg::KIND_DATA};
    res_b        = '{data: 8'h00, kind: sled_pkg::KIND_DATA};

    // simple escapes
    esc_hit = 1'b1;
    esc_val = in_tdata;
    case (in_tdata)
      CH_A:     esc_val = 8'd7;
      CH_B:     esc_val = 8'd8;
      CH_F:     esc_val = 8'd12;
      CH_N:     esc_val = 8'd10;
      CH_R:     esc_val = 8'd13;
      CH_T:     esc_val = 8'd9;
      CH_V:     esc_val = 8'd11;
      CH_BSL:   esc_val = CH_BSL;
      CH_QUOTE: esc_val = CH_QUOTE;
      CH_APOS:  esc_val = CH_APOS;
      CH_QMARK: esc_val = CH_QMARK;
      default:  esc_hit = 1'b0;
    endcase

    case (phase_r)
      PH_OPEN: begin
        if (in_tdata == CH_QUOTE) begin
          phase_nxt = PH_STR;
        end else if (in_tdata != CH_SPACE && in_tdata != CH_TAB) begin
          em_a       = 1'b1;
          res_a.kind = sled_pkg::KIND_ERROR;
          phase_nxt  = err_ph;
        end
      end
      PH_STR: begin
        em_a      = lit.emit;
        res_a     = lit.r;
        phase_nxt = lit.ph;
      end
      PH_ESC: begin
        if (in_tdata == CH_NUL) begin
          em_a       = 1'b1;
          res_a.kind = sled_pkg::KIND_ERROR;
          phase_nxt  = PH_OPEN;
        end else if (esc_hit) begin
          em_a       = 1'b1;
          res_a.data = esc_val;
          phase_nxt  = PH_STR;
        end else if (in_tdata == CH_X) begin
          accum_nxt    = 8'h00;
          hex_seen_nxt = 1'b0;
          phase_nxt    = PH_HEX;
        end else if (is_oct) begin
          accum_nxt = {5'd0, in_tdata[2:0]};
          oct_nxt   = 2'd1;
          phase_nxt = PH_OCT;
        end else begin
          em_a       = 1'b1;
          res_a.kind = sled_pkg::KIND_ERROR;
          phase_nxt  = PH_DRAIN;
        end
      end
      PH_HEX: begin
        if (hx[4]) begin
          accum_nxt    = {accum_r[3:0], hx[3:0]};
          hex_seen_nxt = 1'b1;
        end else if (!hex_seen_r) begin
          em_a       = 1'b1;
          res_a.kind = sled_pkg::KIND_ERROR;
          phase_nxt  = err_ph;
        end else begin
          // escape ends; terminating char handled as a literal char
          em_a       = 1'b1;
          res_a.data = accum_r;
          em_b       = lit.emit;
          res_b      = lit.r;
          phase_nxt  = lit.ph;
        end
      end
      PH_OCT: begin
        if (is_oct) begin
          accum_nxt = {accum_r[4:0], in_tdata[2:0]};
          oct_nxt   = oct_r + 2'd1;
          if (oct_r >= 2'd2) begin
            em_a       = 1'b1;
            res_a.data = {accum_r[4:0], in_tdata[2:0]};
            oct_nxt    = 2'd0;
            phase_nxt  = PH_STR;
          end
        end else begin
          em_a       = 1'b1;
          res_a.data = accum_r;
          oct_nxt    = 2'd0;
          em_b       = lit.emit;
          res_b      = lit.r;
          phase_nxt  = lit.ph;
        end
      end
      PH_CLOSE: begin
        if (in_tdata == CH_SPACE || in_tdata == CH_TAB) begin
          phase_nxt = PH_CLOSE;
        end else if (in_tdata == CH_COMMA) begin
          phase_nxt = PH_OPEN;
        end else if (in_tdata == CH_QUOTE) begin
          phase_nxt = PH_STR;
        end else if (in_tdata == CH_NUL) begin
          em_a      = 1'b1;
          phase_nxt = PH_OPEN;
          if (append_nul) begin
            em_b       = 1'b1;
            res_b.kind = sled_pkg::KIND_DONE;
          end else begin
            res_a.kind = sled_pkg::KIND_DONE;
          end
        end else begin
          em_a       = 1'b1;
          res_a.kind = sled_pkg::KIND_ERROR;
          phase_nxt  = PH_DRAIN;
        end
      end
      PH_DRAIN: begin
        if (in_tdata == CH_NUL) phase_nxt = PH_OPEN;
      end
      default: begin
        phase_nxt = PH_OPEN;
      end
    endcase
  end

  assign q_push     = fire && em_a;
  assign q_wdata.two = em_b;
  assign q_wdata.r0  = res_a;
  assign q_wdata.r1  = res_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_OPEN;
      accum_r    <= 8'h00;
      oct_r      <= 2'd0;
      hex_seen_r <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      accum_r    <= accum_nxt;
      oct_r      <= oct_nxt;
      hex_seen_r <= hex_seen_nxt;
    end
  end

endmodule

// ===== rtl/sled_queue.sv =====
// Small FIFO of result entries between parser and output stage.
`timescale 1ns / 1ps

module sled_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sled_pkg::q_entry_t  wdata,
  input  logic                pop,
  output sled_pkg::q_entry_t  rdata,
  output sled_pkg::q_status_t st
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sled_pkg::q_entry_t slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign st.full  = (count_r == CW'(DEPTH));
  assign st.empty = (count_r == '0);
  assign rdata    = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (!push && pop) count_r <= count_r - CW'(1);
    end
  end

endmodule

// ===== rtl/sled_back.sv =====
// Back end: splits queue entries into result beats behind an output register.
`timescale 1ns / 1ps

module sled_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sled_pkg::q_entry_t  q_rdata,
  input  sled_pkg::q_status_t q_st,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // [7:0] out_byte
  output logic [1:0]          out_tuser,  // [1:0] result_kind
  output logic                out_tlast   // last_of_item
);

  logic           valid_r;
  sled_pkg::res_t res_r;
  logic           last_r;
  logic           half_r;   // first result of a two-result entry sent
  logic           load;
  logic           first_only;

  assign load       = (!valid_r || out_tready) && !q_st.empty;
  assign first_only = q_rdata.two && !half_r;
  assign q_pop      = load && !first_only;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      half_r  <= first_only;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= half_r ? q_rdata.r1 : q_rdata.r0;
      last_r <= !first_only;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.data;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = last_r;

endmodule

// ===== rtl/string_literal_escape_decoder_top.sv =====
// Top level of the string literal escape decoder.
`timescale 1ns / 1ps
//
// Decodes a list of double-quoted C string literals, one source character
// per input beat (in_tdata; 0 ends the text), into a stream of result beats.
// Result beat: out_tdata = decoded byte, out_tuser = kind (0 data, 1 done,
// 2 error), out_tlast = last result caused by that input character.
// A character yields zero, one or two results.
// Config: APB-style port, register 0 (byte address 0) = append_nul, bit 0.
// When set, a zero data byte is sent ahead of the done beat.
// Throughput: one character per cycle while the queue is not full.
// The output stage sends one result per cycle while out_tready is high,
// so a character that causes two results adds an output beat; the queue
// absorbs the burst. A result is offered on out_tvalid after the accepted
// character is written to the queue and then to the output register.
// Stall: when out_tready is low the output register holds, the queue fills
// (Q_DEPTH entries) and in_tready drops once it is full.
// Reset (rst_n low, synchronous): parser back to expecting an opening
// quote, queue emptied, output invalid, append_nul cleared.
//
module string_literal_escape_decoder_top #(
  parameter int Q_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // character stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] text_char
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] out_byte
  output logic [1:0]  out_tuser,   // [1:0] result_kind
  output logic        out_tlast,   // last_of_item
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic append_nul_r;
  logic cfg_wr;

  sled_pkg::q_entry_t  q_wdata, q_rdata;
  sled_pkg::q_status_t q_st;
  logic                q_push, q_pop;

  // config port: cfg_pready always high, paddr[2] selects the register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == sled_pkg::REG_IDX_APPEND_NUL) ?
                      {31'd0, append_nul_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      append_nul_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr[2] == sled_pkg::REG_IDX_APPEND_NUL) begin
      append_nul_r <= cfg_pwdata[0];
    end
  end

  // parser: classifies each character into queue entries
  sled_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .append_nul (append_nul_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_st       (q_st),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  sled_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .st    (q_st)
  );

  // output stage: one result beat per cycle while out_tready is high
  sled_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rdata    (q_rdata),
    .q_st       (q_st),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/sled_checker.sv =====
// Port-level assertions for the string literal escape decoder, with bind.
`timescale 1ns / 1ps

module sled_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // done and error always close the results of their character
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'(sled_pkg::KIND_DATA) |-> out_tlast)
    else $error("status beat without tlast");

  // status beats carry a zero byte, and no unused kind appears
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != 2'(sled_pkg::KIND_DATA) |->
      out_tdata == 8'h00 && out_tuser != 2'd3)
    else $error("bad status beat");

  // reset empties the output register and the queue
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not idle after reset");

endmodule

bind string_literal_escape_decoder_top sled_checker u_sled_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
